// ----- rtl/assert_macros.svh -----
// Assertion helpers used by rgb_to_hsl.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define RTH_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rgb_to_hsl check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define RTH_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rgb_to_hsl check failed");

`endif

// ----- rtl/rth_pkg.sv -----
`default_nettype none

package rth_pkg;

   // Divider datapath widths
   localparam int DIV_W     = 11;          // numerator and divisor bits
   localparam int REM_W     = DIV_W + 1;   // partial remainder after a shift
   localparam int Q_W       = 17;          // integer bit plus 16 fraction bits
   localparam int DIV_STEPS = Q_W;         // one quotient bit per step
   localparam int DIV_SPS   = 4;           // steps per register stage
   localparam int DIV_STAGES = (DIV_STEPS + DIV_SPS - 1) / DIV_SPS;

   // input reg + front stage + divisor stage + divider + output reg
   localparam int LATENCY = 3 + DIV_STAGES + 1;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [15:0] hue;
      logic [16:0] saturation;
      logic [16:0] lightness;
   } hsl_type;

   // Channel statistics handed from the front stage
   typedef struct packed {
      logic [8:0]       sum;
      logic [7:0]       spread;
      logic [DIV_W-1:0] hue_num;
      logic             gray;
   } front_type;

endpackage

`default_nettype wire

// ----- rtl/rth_front.sv -----
`default_nettype none

module rth_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire rth_pkg::pixel_type in_pixel,
   output logic                    out_valid,
   output rth_pkg::front_type      out_stats
);

   logic [7:0]                mx;
   logic [7:0]                mn;
   logic [7:0]                spread;
   logic [rth_pkg::DIV_W-1:0] d_ext;
   logic [rth_pkg::DIV_W-1:0] r_ext;
   logic [rth_pkg::DIV_W-1:0] g_ext;
   logic [rth_pkg::DIV_W-1:0] b_ext;
   rth_pkg::front_type        stats_in;
   rth_pkg::front_type        stats_ff;
   logic                      valid_ff;

   // Find largest and smallest channel, then the hue numerator of the sector
   always_comb begin
      mx = in_pixel.red;
      mn = in_pixel.red;
      if (in_pixel.green > mx) mx = in_pixel.green;
      if (in_pixel.blue > mx) mx = in_pixel.blue;
      if (in_pixel.green < mn) mn = in_pixel.green;
      if (in_pixel.blue < mn) mn = in_pixel.blue;

      spread = mx - mn;
      d_ext  = {{(rth_pkg::DIV_W-8){1'b0}}, spread};
      r_ext  = {{(rth_pkg::DIV_W-8){1'b0}}, in_pixel.red};
      g_ext  = {{(rth_pkg::DIV_W-8){1'b0}}, in_pixel.green};
      b_ext  = {{(rth_pkg::DIV_W-8){1'b0}}, in_pixel.blue};

      stats_in.sum    = {1'b0, mx} + {1'b0, mn};
      stats_in.spread = spread;
      stats_in.gray   = (mx == mn);

      // Red wins ties over green, green over blue
      if (mx == in_pixel.red) begin
         if (in_pixel.green < in_pixel.blue) begin
            stats_in.hue_num = (d_ext << 2) + (d_ext << 1) - (b_ext - g_ext);
         end else begin
            stats_in.hue_num = g_ext - b_ext;
         end
      end else if (mx == in_pixel.green) begin
         stats_in.hue_num = (d_ext << 1) + b_ext - r_ext;
      end else begin
         stats_in.hue_num = (d_ext << 2) + r_ext - g_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      stats_ff <= stats_in;
   end

   assign out_valid = valid_ff;
   assign out_stats = stats_ff;

endmodule

`default_nettype wire

// ----- rtl/rth_div.sv -----
`default_nettype none

// Pipelined restoring divider: quo = floor(num * 2^16 / den), num <= den.
module rth_div (
   input  wire logic                      clock,
   input  wire logic [rth_pkg::DIV_W-1:0] num,
   input  wire logic [rth_pkg::DIV_W-1:0] den,
   output logic      [rth_pkg::Q_W-1:0]   quo
);

   localparam int STAGES = rth_pkg::DIV_STAGES;
   localparam int SPS    = rth_pkg::DIV_SPS;
   localparam int REM_W  = rth_pkg::REM_W;
   localparam int DIV_W  = rth_pkg::DIV_W;
   localparam int Q_W    = rth_pkg::Q_W;

   logic [REM_W-1:0] rem_ff [STAGES-1];
   logic [DIV_W-1:0] den_ff [STAGES-1];
   logic [Q_W-1:0]   quo_ff [STAGES];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      logic [REM_W-1:0] rem_cur;
      logic [DIV_W-1:0] den_cur;
      logic [Q_W-1:0]   quo_cur;
      logic [REM_W-1:0] rem_in;
      logic [Q_W-1:0]   quo_in;

      if (s == 0) begin : g_first
         assign rem_cur = {1'b0, num};
         assign den_cur = den;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[s-1];
         assign den_cur = den_ff[s-1];
         assign quo_cur = quo_ff[s-1];
      end

      // Resolve up to SPS quotient bits; the first step has no shift
      always_comb begin
         rem_in = rem_cur;
         quo_in = quo_cur;
         for (int j = 0; j < SPS; j++) begin
            if (s * SPS + j < rth_pkg::DIV_STEPS) begin
               if (s * SPS + j != 0) begin
                  rem_in = {rem_in[REM_W-2:0], 1'b0};
               end
               if (rem_in >= {1'b0, den_cur}) begin
                  rem_in = rem_in - {1'b0, den_cur};
                  quo_in = {quo_in[Q_W-2:0], 1'b1};
               end else begin
                  quo_in = {quo_in[Q_W-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         quo_ff[s] <= quo_in;
      end

      if (s < STAGES - 1) begin : g_carry
         always_ff @(posedge clock) begin
            rem_ff[s] <= rem_in;
            den_ff[s] <= den_cur;
         end
      end
   end

   assign quo = quo_ff[STAGES-1];

endmodule

`default_nettype wire

// ----- rtl/rgb_to_hsl.sv -----
`default_nettype none

// Channel    Ports                      Beat taken when
// ---------  -------------------------  ----------------------------
// pixel in   start, busy, req_pixel     start high and busy low
// HSL out    rsp_valid, rsp_hsl         rsp_valid high (one cycle)
//
// One pixel enters every cycle; busy is never raised.
// Each result passes, after its pixel is taken, through the input register,
// channel stats, divisor set-up, five divider stages and the output register.
// The dividers resolve four quotient bits per stage, which sets the depth.
// Synchronous reset empties the pipeline; beats in flight are dropped.
// The receiver cannot stall, so the pipeline never holds.
`include "assert_macros.svh"

module rgb_to_hsl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire rth_pkg::pixel_type req_pixel,
   output logic                    rsp_valid,
   output rth_pkg::hsl_type        rsp_hsl
);

   localparam int DIV_W  = rth_pkg::DIV_W;
   localparam int STAGES = rth_pkg::DIV_STAGES;

   logic                 in_valid_ff;
   rth_pkg::pixel_type   pixel_ff;
   logic                 front_valid;
   rth_pkg::front_type   front_stats;
   logic                 den_valid_ff;
   logic                 den_gray_ff;
   logic [DIV_W-1:0]     hue_num_ff;
   logic [DIV_W-1:0]     hue_den_ff;
   logic [DIV_W-1:0]     sat_num_ff;
   logic [DIV_W-1:0]     sat_den_ff;
   logic [8:0]           sat_den_in;
   logic [DIV_W-1:0]     spread_ext;
   logic [15:0]          lit_base;
   logic [16:0]          lit_round;
   logic [16:0]          lit_in;
   logic [16:0]          lit_den_ff;
   logic                 div_valid_ff [STAGES];
   logic                 div_gray_ff  [STAGES];
   logic [16:0]          div_lit_ff   [STAGES];
   logic [rth_pkg::Q_W-1:0] hue_quo;
   logic [rth_pkg::Q_W-1:0] sat_quo;
   logic                 rsp_valid_ff;
   rth_pkg::hsl_type     rsp_hsl_ff;

   assign busy = 1'b0;

   // Capture the incoming pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= req_pixel;
   end

   rth_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_pixel  (pixel_ff),
      .out_valid (front_valid),
      .out_stats (front_stats)
   );

   // Set up divisors: saturation folds around mid-grey, hue spans six sectors
   assign sat_den_in = (front_stats.sum > 9'd255) ? (9'd510 - front_stats.sum)
                                                  : front_stats.sum;
   assign spread_ext = {{(DIV_W-8){1'b0}}, front_stats.spread};

   // Lightness: sum * 2^16 / 510 is 128 * sum plus floor(128 * sum / 255)
   assign lit_base  = {front_stats.sum, 7'd0};
   assign lit_round = {1'b0, lit_base} + 17'd1 + {9'd0, lit_base[15:8]};
   assign lit_in    = {1'b0, lit_base} + {8'd0, lit_round[16:8]};

   always_ff @(posedge clock) begin
      if (reset) begin
         den_valid_ff <= 1'b0;
      end else begin
         den_valid_ff <= front_valid;
      end
   end

   always_ff @(posedge clock) begin
      den_gray_ff <= front_stats.gray;
      hue_num_ff  <= front_stats.hue_num;
      hue_den_ff  <= (spread_ext << 2) + (spread_ext << 1);
      sat_num_ff  <= spread_ext;
      sat_den_ff  <= {{(DIV_W-9){1'b0}}, sat_den_in};
      lit_den_ff  <= lit_in;
   end

   rth_div u_div_hue (
      .clock (clock),
      .num   (hue_num_ff),
      .den   (hue_den_ff),
      .quo   (hue_quo)
   );

   rth_div u_div_sat (
      .clock (clock),
      .num   (sat_num_ff),
      .den   (sat_den_ff),
      .quo   (sat_quo)
   );

   // Carry valid and grey flags and lightness alongside the divider stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STAGES; s++) begin
            div_valid_ff[s] <= 1'b0;
         end
      end else begin
         div_valid_ff[0] <= den_valid_ff;
         for (int s = 1; s < STAGES; s++) begin
            div_valid_ff[s] <= div_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      div_gray_ff[0] <= den_gray_ff;
      div_lit_ff[0]  <= lit_den_ff;
      for (int s = 1; s < STAGES; s++) begin
         div_gray_ff[s] <= div_gray_ff[s-1];
         div_lit_ff[s]  <= div_lit_ff[s-1];
      end
   end

   // Register the result; grey pixels drop hue and saturation
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid_ff[STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (div_gray_ff[STAGES-1]) begin
         rsp_hsl_ff.hue        <= '0;
         rsp_hsl_ff.saturation <= '0;
      end else begin
         rsp_hsl_ff.hue        <= hue_quo[15:0];
         rsp_hsl_ff.saturation <= sat_quo;
      end
      rsp_hsl_ff.lightness <= div_lit_ff[STAGES-1];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hsl   = rsp_hsl_ff;

   `RTH_ASSERT_IMPL(a_latency, start && !busy, ##(rth_pkg::LATENCY) rsp_valid)
   `RTH_ASSERT_NEXT(a_gray_zero, div_valid_ff[STAGES-1] && div_gray_ff[STAGES-1],
                    rsp_hsl.hue == 16'd0 && rsp_hsl.saturation == 17'd0)
   `RTH_ASSERT_IMPL(a_sat_range, rsp_valid,
                    rsp_hsl.saturation <= 17'd65536 && rsp_hsl.lightness <= 17'd65536)

endmodule

`default_nettype wire

// ----- sim/rgb_to_hsl_checker.sv -----
`timescale 1ns / 1ps

module rgb_to_hsl_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire rth_pkg::pixel_type req_pixel,
   input  wire logic               rsp_valid,
   input  wire rth_pkg::hsl_type   rsp_hsl,
   output int                      fail_count,
   output int                      pending_beats
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      rth_pkg::pixel_type pixel;
      rth_pkg::hsl_type   hsl;
   } expected_beat_type;

   expected_beat_type expected_hsl[$];

   initial begin
      fail_count    = 0;
      pending_beats = 0;
   end

   // num / den as a 16-bit binary fraction, truncated; a zero divisor gives zero
   function automatic int unsigned frac_quotient(input int unsigned num,
                                                 input int unsigned den);
      longint unsigned wide_num;
      wide_num = longint'(num) << 16;
      if (den == 0)
         return 0;
      return int'(wide_num / den);
   endfunction

   // Expected hue, saturation and lightness of one pixel
   function automatic rth_pkg::hsl_type convert_pixel(input rth_pkg::pixel_type px);
      int      r, g, b, top_ch, low_ch, total, spread, hue_num;
      rth_pkg::hsl_type res;
      r      = px.red;
      g      = px.green;
      b      = px.blue;
      top_ch = r;
      low_ch = r;
      if (g > top_ch) top_ch = g;
      if (b > top_ch) top_ch = b;
      if (g < low_ch) low_ch = g;
      if (b < low_ch) low_ch = b;
      total  = top_ch + low_ch;
      spread = top_ch - low_ch;

      res.lightness  = 17'(frac_quotient(total, 510));
      res.saturation = '0;
      res.hue        = '0;

      // gray pixels keep zero hue and saturation
      if (spread != 0) begin
         if (total > 255)
            res.saturation = 17'(frac_quotient(spread, 510 - total));
         else
            res.saturation = 17'(frac_quotient(spread, total));

         // red wins ties for the maximum, then green
         if (top_ch == r) begin
            if (g < b)
               hue_num = 6 * spread - (b - g);
            else
               hue_num = g - b;
         end else if (top_ch == g) begin
            hue_num = 2 * spread + b - r;
         end else begin
            hue_num = 4 * spread + r - g;
         end
         res.hue = 16'(frac_quotient(hue_num, 6 * spread));
      end
      return res;
   endfunction

   // Compare each result beat with the oldest expectation, then log new pixels
   always @(posedge clock) begin
      expected_beat_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_hsl.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: hsl beat with no pixel outstanding: hue %0d sat %0d lit %0d",
                           $time, rsp_hsl.hue, rsp_hsl.saturation, rsp_hsl.lightness);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_hsl.pop_front();
               if (rsp_hsl !== want.hsl) begin
                  if (fail_count < REPORT_LIMIT)
                     $display({"%0t: rgb %0d/%0d/%0d: expected hue %0d sat %0d lit %0d,",
                               " got hue %0d sat %0d lit %0d"},
                              $time, want.pixel.red, want.pixel.green, want.pixel.blue,
                              want.hsl.hue, want.hsl.saturation, want.hsl.lightness,
                              rsp_hsl.hue, rsp_hsl.saturation, rsp_hsl.lightness);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) begin
            want.pixel = req_pixel;
            want.hsl   = convert_pixel(req_pixel);
            expected_hsl.push_back(want);
         end
      end
      pending_beats <= expected_hsl.size();
   end

endmodule

// ----- sim/rgb_to_hsl_tb.sv -----
`timescale 1ns / 1ps

module rgb_to_hsl_tb;

   localparam int RANDOM_PIXELS = 2000;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 3;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   rth_pkg::pixel_type req_pixel = '0;
   logic               rsp_valid;
   rth_pkg::hsl_type   rsp_hsl;

   logic      beat_taken = 1'b0;
   int        cycle_count = 0;
   int        fail_count;
   int        pending_beats;
   bit        idle_on;

   rgb_to_hsl dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_hsl   (rsp_hsl)
   );

   rgb_to_hsl_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_pixel     (req_pixel),
      .rsp_valid     (rsp_valid),
      .rsp_hsl       (rsp_hsl),
      .fail_count    (fail_count),
      .pending_beats (pending_beats)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Note each pixel beat taken, for the driver to see at the falling edge
   always @(posedge clock) begin
      beat_taken <= !reset && start && !busy;
   end

   // Hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rgb_to_hsl: mismatch");
         $finish;
      end
   end

   // Present one pixel, hold it until taken, sometimes idle before the next
   task automatic send_pixel(input rth_pkg::pixel_type px);
      start     = 1'b1;
      req_pixel = px;
      do @(negedge clock); while (!beat_taken);
      if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
         start     = 1'b0;
         req_pixel = rth_pkg::pixel_type'($urandom);
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   initial begin
      rth_pkg::pixel_type px;
      logic [7:0] lo, hi;
      idle_on = 1'b1;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Directed: extremes, gray, each sector, ties for the maximum, sum boundary
      send_pixel({8'h00, 8'h00, 8'h00});
      send_pixel({8'hFF, 8'hFF, 8'hFF});
      send_pixel({8'h80, 8'h80, 8'h80});
      send_pixel({8'hFF, 8'h00, 8'h00});
      send_pixel({8'h00, 8'hFF, 8'h00});
      send_pixel({8'h00, 8'h00, 8'hFF});
      send_pixel({8'hFF, 8'hFF, 8'h00});
      send_pixel({8'h00, 8'hFF, 8'hFF});
      send_pixel({8'hFF, 8'h00, 8'hFF});
      send_pixel({8'hFF, 8'h00, 8'h80});
      send_pixel({8'hFF, 8'h80, 8'h00});
      send_pixel({8'h80, 8'hFF, 8'h00});
      send_pixel({8'h00, 8'h80, 8'hFF});
      send_pixel({8'h80, 8'h7F, 8'h7F});
      send_pixel({8'h80, 8'h80, 8'h81});
      send_pixel({8'h01, 8'h00, 8'h00});
      send_pixel({8'hFE, 8'hFF, 8'hFF});
      send_pixel({8'h7F, 8'h00, 8'h80});
      send_pixel({8'hAA, 8'hAA, 8'h55});
      send_pixel({8'h55, 8'hAA, 8'hAA});
      send_pixel({8'h12, 8'h34, 8'h56});
      send_pixel({8'hC8, 8'h37, 8'h64});

      // Random: mostly uniform, with gray, tied maxima, near-extreme and
      // sum-near-255 pixels mixed in; one long stretch runs without gaps
      for (int n = 0; n < RANDOM_PIXELS; n++) begin
         idle_on = !(n >= 700 && n < 1200);
         px = rth_pkg::pixel_type'($urandom);
         case ($urandom_range(9))
            0: begin
               px.green = px.red;
               px.blue  = px.red;
            end
            1: begin
               hi = 8'($urandom_range(1, 255));
               lo = 8'($urandom_range(0, hi - 1));
               case ($urandom_range(2))
                  0: px = {hi, hi, lo};
                  1: px = {lo, hi, hi};
                  default: px = {hi, lo, hi};
               endcase
            end
            2: begin
               px.red   = $urandom_range(1) ? 8'($urandom_range(0, 3))
                                            : 8'($urandom_range(252, 255));
               px.green = $urandom_range(1) ? 8'($urandom_range(0, 3))
                                            : 8'($urandom_range(252, 255));
               px.blue  = $urandom_range(1) ? 8'($urandom_range(0, 3))
                                            : 8'($urandom_range(252, 255));
            end
            3: begin
               px.red   = 8'($urandom_range(124, 131));
               px.green = 8'($urandom_range(124, 131));
               px.blue  = 8'($urandom_range(124, 131));
            end
            default: ;
         endcase
         send_pixel(px);
      end

      // Drain and let the pipeline settle
      start = 1'b0;
      while (pending_beats != 0) @(negedge clock);
      repeat (rth_pkg::LATENCY + 4) @(negedge clock);

      if (fail_count == 0 && pending_beats == 0)
         $display("rgb_to_hsl: match");
      else
         $display("rgb_to_hsl: mismatch");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/rth_pkg.sv
rtl/rth_front.sv
rtl/rth_div.sv
rtl/rgb_to_hsl.sv
sim/rgb_to_hsl_checker.sv
sim/rgb_to_hsl_tb.sv
